### hw/rtl/bmprle_pkg.sv
// shared types and constants for the rle8 line boundary scanner
package bmprle_pkg;

  // field widths
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned PIX_W    = 17;
  localparam int unsigned BYTES_W  = 20;
  localparam int unsigned INDEX_W  = 16;
  localparam int unsigned OFFSET_W = 32;

  // saturation limits
  localparam logic [PIX_W-1:0]    PIX_MAX    = '1;
  localparam logic [BYTES_W-1:0]  BYTES_MAX  = '1;
  localparam logic [INDEX_W-1:0]  INDEX_MAX  = '1;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

  // width register value after reset
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET = WIDTH_W'(1);

  // stream byte codes
  localparam logic [BYTE_W-1:0] CODE_ESCAPE = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_DELTA  = 8'h02;
  localparam logic [BYTE_W-1:0] CODE_ABS    = 8'h03;

  // token parse phase
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_ESC    = 2'd1,
    PH_RUNVAL = 2'd2,
    PH_SKIP   = 2'd3
  } bmprle_phase_t;

  // one completed line
  typedef struct packed {
    logic [INDEX_W-1:0]  line_index;
    logic [BYTES_W-1:0]  line_bytes;
    logic [OFFSET_W-1:0] line_end_offset;
    logic                pixel_overrun;
  } bmprle_result_t;

endpackage

### hw/rtl/bmprle_scan_core.sv
// token parser and line counters, one stream byte per accepted transaction
module bmprle_scan_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_acc,
  input  logic [bmprle_pkg::BYTE_W-1:0]    stream_byte,
  input  logic                             start_image,
  input  logic [bmprle_pkg::WIDTH_W-1:0]   line_width,
  output logic                             res_valid,
  output bmprle_pkg::bmprle_result_t       res
);
  import bmprle_pkg::*;

  // parser and line state
  bmprle_phase_t       phase_r, phase_nxt;
  logic [BYTE_W-1:0]   skip_r, skip_nxt;
  logic [BYTE_W-1:0]   held_r, held_nxt;
  logic [PIX_W-1:0]    pix_r, pix_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;
  logic [INDEX_W-1:0]  count_r, count_nxt;
  logic [OFFSET_W-1:0] offset_r, offset_nxt;
  logic                line_end;

  // next state for the byte at the input
  always_comb begin
    bmprle_phase_t       ph;
    logic [BYTE_W-1:0]   sk;
    logic [BYTE_W-1:0]   hd;
    logic [PIX_W-1:0]    px;
    logic [BYTES_W-1:0]  by;
    logic [INDEX_W-1:0]  ct;
    logic [OFFSET_W-1:0] of;
    logic [BYTE_W-1:0]   add_amt;
    logic [PIX_W:0]      pix_sum;
    logic                done;

    // start of image clears progress before this byte
    ph = start_image ? PH_FIRST : phase_r;
    sk = start_image ? '0 : skip_r;
    hd = start_image ? '0 : held_r;
    px = start_image ? '0 : pix_r;
    by = start_image ? '0 : bytes_r;
    ct = start_image ? '0 : count_r;
    of = start_image ? '0 : offset_r;

    // byte counters saturate
    if (by != BYTES_MAX) by = by + BYTES_W'(1);
    if (of != OFFSET_MAX) of = of + OFFSET_W'(1);

    add_amt = '0;
    done    = 1'b0;
    phase_nxt = ph;
    skip_nxt  = sk;
    held_nxt  = hd;

    unique case (ph)
      PH_FIRST: begin
        if (stream_byte != CODE_ESCAPE) begin
          held_nxt  = stream_byte;
          phase_nxt = PH_RUNVAL;
        end else begin
          phase_nxt = PH_ESC;
        end
      end
      PH_ESC: begin
        if (stream_byte >= CODE_ABS) begin
          // absolute run, data padded to even length, counter holds remaining minus one
          add_amt   = stream_byte;
          skip_nxt  = stream_byte[0] ? stream_byte : stream_byte - BYTE_W'(1);
          phase_nxt = PH_SKIP;
        end else if (stream_byte == CODE_DELTA) begin
          skip_nxt  = BYTE_W'(1);
          phase_nxt = PH_SKIP;
        end else begin
          done = 1'b1;
        end
      end
      PH_RUNVAL: begin
        add_amt  = hd;
        held_nxt = '0;
        done     = 1'b1;
      end
      PH_SKIP: begin
        if (sk == '0) done = 1'b1;
        else skip_nxt = sk - BYTE_W'(1);
      end
      default: begin
        phase_nxt = PH_FIRST;
      end
    endcase

    // pixel count saturates
    pix_sum = {1'b0, px} + (PIX_W+1)'(add_amt);
    px      = (pix_sum > {1'b0, PIX_MAX}) ? PIX_MAX : pix_sum[PIX_W-1:0];

    if (done) phase_nxt = PH_FIRST;
    line_end = done && (px >= PIX_W'(line_width));

    // result fields
    res.line_index      = ct;
    res.line_bytes      = by;
    res.line_end_offset = of;
    res.pixel_overrun   = (px > PIX_W'(line_width));

    if (line_end) begin
      if (ct != INDEX_MAX) ct = ct + INDEX_W'(1);
      px = '0;
      by = '0;
    end

    pix_nxt    = px;
    bytes_nxt  = by;
    count_nxt  = ct;
    offset_nxt = of;
  end

  assign res_valid = in_acc && line_end;

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_FIRST;
      skip_r   <= '0;
      held_r   <= '0;
      pix_r    <= '0;
      bytes_r  <= '0;
      count_r  <= '0;
      offset_r <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      skip_r   <= skip_nxt;
      held_r   <= held_nxt;
      pix_r    <= pix_nxt;
      bytes_r  <= bytes_nxt;
      count_r  <= count_nxt;
      offset_r <= offset_nxt;
    end
  end

  // a line end restarts pixel and byte counts
  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> (pix_r == '0) && (bytes_r == '0) && (phase_r == PH_FIRST))
    else $error("line end did not clear line progress");

  // a run count is only held while waiting for its run value byte
  a_held_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != '0) |-> (phase_r == PH_RUNVAL))
    else $error("run count held outside run value phase");

  // the running offset advances on each accepted byte within an image
  a_offset_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !start_image && offset_r != OFFSET_MAX) |=> (offset_r == $past(offset_r) + 1'b1))
    else $error("running offset did not advance");

endmodule

### hw/rtl/bmp_rle8_line_boundary_scanner.sv
// top level: config register, scan core and output skid buffer
//
//   channel  dir  handshake              payload
//   in       in   in_valid / in_ready    in_stream_byte[7:0], in_start_image
//   out      out  out_valid / out_ready  out_line_index, out_line_bytes,
//                                        out_line_end_offset, out_pixel_overrun
//   cfg      in   cfg_valid / cfg_ready  cfg_line_width[15:0]
//
// one stream byte per cycle while in_ready is high; a line result is registered
// into the output register, or into the skid entry if the output stalls.
// the output register plus one skid entry let input continue while a result
// waits; input stalls only when both hold results.
// synchronous active-low reset: parser idle, counters zero, width 1.
// cfg_ready is always high.
module bmp_rle8_line_boundary_scanner (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bmprle_pkg::BYTE_W-1:0]       in_stream_byte,
  input  logic                                in_start_image,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [bmprle_pkg::INDEX_W-1:0]      out_line_index,
  output logic [bmprle_pkg::BYTES_W-1:0]      out_line_bytes,
  output logic [bmprle_pkg::OFFSET_W-1:0]     out_line_end_offset,
  output logic                                out_pixel_overrun,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmprle_pkg::WIDTH_W-1:0]      cfg_line_width
);
  import bmprle_pkg::*;

  logic [WIDTH_W-1:0] width_r;
  logic               in_acc;
  logic               res_valid;
  bmprle_result_t     res;
  logic               out_valid_r;
  bmprle_result_t     out_r;
  logic               skid_valid_r;
  bmprle_result_t     skid_r;
  logic               pop;

  // config register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      width_r <= cfg_line_width;
    end
  end

  // input transaction
  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;

  bmprle_scan_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_acc      (in_acc),
    .stream_byte (in_stream_byte),
    .start_image (in_start_image),
    .line_width  (width_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  // output register with one skid entry
  assign pop = out_valid_r && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      if (skid_valid_r) out_r <= skid_r;
      else if (res_valid) out_r <= res;
    end else if (res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_index      = out_r.line_index;
  assign out_line_bytes      = out_r.line_bytes;
  assign out_line_end_offset = out_r.line_end_offset;
  assign out_pixel_overrun   = out_r.pixel_overrun;

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid with empty output register");

  // a new result against a stalled output goes to the skid entry
  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && out_valid_r && !out_ready) |=> skid_valid_r)
    else $error("result dropped while output stalled");

  // a waiting skid entry moves to the output when the output is taken
  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && pop) |=> (out_valid_r && !skid_valid_r))
    else $error("skid entry did not drain");

endmodule
